>>> hdl/c6502_ex_pkg.sv
`default_nettype none

package c6502_ex_pkg;

	// Operation codes as carried in the input item.
	typedef enum logic [5:0] {
		OP_LDA = 6'd0,  OP_STA = 6'd1,  OP_LDX = 6'd2,  OP_STX = 6'd3,
		OP_LDY = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TXA = 6'd7,
		OP_TAY = 6'd8,  OP_TYA = 6'd9,  OP_ADC = 6'd10, OP_SBC = 6'd11,
		OP_INC = 6'd12, OP_DEC = 6'd13, OP_INX = 6'd14, OP_DEX = 6'd15,
		OP_INY = 6'd16, OP_DEY = 6'd17, OP_ASL = 6'd18, OP_LSR = 6'd19,
		OP_ROL = 6'd20, OP_ROR = 6'd21, OP_AND = 6'd22, OP_ORA = 6'd23,
		OP_EOR = 6'd24, OP_BIT = 6'd25, OP_CMP = 6'd26, OP_CPX = 6'd27,
		OP_CPY = 6'd28, OP_PHA = 6'd29, OP_PLA = 6'd30, OP_PHP = 6'd31,
		OP_PLP = 6'd32, OP_TXS = 6'd33, OP_TSX = 6'd34, OP_CLC = 6'd35,
		OP_SEC = 6'd36, OP_CLI = 6'd37, OP_SEI = 6'd38, OP_CLD = 6'd39,
		OP_SED = 6'd40, OP_CLV = 6'd41, OP_NOP = 6'd42
	} op_t;

	// Status register bit positions (NV-BDIZC).
	localparam int FlagC = 0;
	localparam int FlagZ = 1;
	localparam int FlagI = 2;
	localparam int FlagD = 3;
	localparam int FlagV = 6;
	localparam int FlagN = 7;

	localparam logic [7:0] PushBits = 8'b0011_0000;
	localparam logic [7:0] PullMask = 8'b1100_1111;

	// Architectural register file.
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} regs_t;

	localparam regs_t RegsReset = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFD, p: 8'h24};

	// Memory and stack access produced by one operation.
	typedef struct packed {
		logic       mem_write;
		logic [7:0] write_data;
		logic       stack_access;
		logic [8:0] stack_address;
	} access_t;

	localparam int InWidth  = 16;
	localparam int OutWidth = 64;

endpackage

`default_nettype wire

>>> hdl/cpu6502_register_alu_execute.sv
// 6502 register and ALU execute block.
// Input channel s_*: one item per decoded operation, carrying the operation
// code and the byte already fetched from the operand or stack address.
// Output channel m_*: one item per input item, carrying the optional memory
// or stack write and the A, X, Y, SP and P registers after the operation.
// An accepted item is held in an input register; once the output register
// is free, the ALU reads it together with the register file, updates the
// register file and loads the output register, which drives m_tvalid.
// Throughput is one item per cycle while m_tready stays high, set by the
// single ALU pass between the input register and the output register.
// When the receiver stalls, the output register holds its item; the item in
// the input register waits, and s_tready drops once both are occupied.
// Reset clears both registers and loads A=0, X=0, Y=0, SP=0xFD, P=0x24.
`default_nettype none

module cpu6502_register_alu_execute
	import c6502_ex_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// [5:0] operation, [13:6] mem_data, [15:14] zero
	input  wire logic [InWidth-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [0] mem_write, [8:1] write_data, [9] stack_access, [18:10] stack_address,
	// [26:19] acc_out, [34:27] index_x_out, [42:35] index_y_out,
	// [50:43] stack_pointer_out, [58:51] status_out, [63:59] zero
	output logic [OutWidth-1:0]      m_tdata
);

	logic       valid_s1;
	logic [5:0] op_s1;
	logic [7:0] data_s1;
	logic       valid_s2;
	regs_t      regs_q;
	regs_t      regs_next;
	access_t    access;
	access_t    access_s2;
	logic       advance;

	// Move the held item through the ALU when the output register is free.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tdata[5:0];
			data_s1 <= s_tdata[13:6];
		end
	end

	c6502_ex_alu u_alu (
		.operation (op_s1),
		.mem_data  (data_s1),
		.regs_cur  (regs_q),
		.regs_next (regs_next),
		.access    (access)
	);

	// Register file updates once per executed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= RegsReset;
		end else if (advance) begin
			regs_q <= regs_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			access_s2 <= access;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, regs_q.p, regs_q.sp, regs_q.y, regs_q.x, regs_q.a,
		access_s2.stack_address, access_s2.stack_access,
		access_s2.write_data, access_s2.mem_write};

endmodule

`default_nettype wire

>>> hdl/c6502_ex_alu.sv
`default_nettype none

module c6502_ex_alu
	import c6502_ex_pkg::*;
(
	input  wire logic [5:0] operation,
	input  wire logic [7:0] mem_data,
	input  wire regs_t      regs_cur,
	output regs_t           regs_next,
	output access_t         access
);

	logic [7:0] m_add;
	logic [8:0] sum9;
	logic       add_ovf;

	// Shared adder for ADC and SBC; SBC adds the complement of the operand.
	always_comb begin
		m_add   = (operation == OP_SBC) ? ~mem_data : mem_data;
		sum9    = {1'b0, regs_cur.a} + {1'b0, m_add} + {8'd0, regs_cur.p[FlagC]};
		add_ovf = ((regs_cur.a[7] ^ sum9[7]) & (m_add[7] ^ sum9[7]));
	end

	// Operation decode and register update.
	always_comb begin
		regs_t      nxt;
		access_t    acc;
		logic       nz_en;
		logic [7:0] nz_val;
		logic [7:0] cmp_reg;
		logic [8:0] diff9;
		logic [7:0] sp_inc;

		nxt     = regs_cur;
		acc     = '0;
		nz_en   = 1'b0;
		nz_val  = 8'd0;
		cmp_reg = regs_cur.a;
		sp_inc  = regs_cur.sp + 8'd1;

		unique case (op_t'(operation))
			OP_LDA: begin nxt.a = mem_data; nz_en = 1'b1; nz_val = mem_data; end
			OP_STA: begin acc.mem_write = 1'b1; acc.write_data = regs_cur.a; end
			OP_LDX: begin nxt.x = mem_data; nz_en = 1'b1; nz_val = mem_data; end
			OP_STX: begin acc.mem_write = 1'b1; acc.write_data = regs_cur.x; end
			OP_LDY: begin nxt.y = mem_data; nz_en = 1'b1; nz_val = mem_data; end
			OP_STY: begin acc.mem_write = 1'b1; acc.write_data = regs_cur.y; end
			OP_TAX: begin nxt.x = regs_cur.a; nz_en = 1'b1; nz_val = regs_cur.a; end
			OP_TXA: begin nxt.a = regs_cur.x; nz_en = 1'b1; nz_val = regs_cur.x; end
			OP_TAY: begin nxt.y = regs_cur.a; nz_en = 1'b1; nz_val = regs_cur.a; end
			OP_TYA: begin nxt.a = regs_cur.y; nz_en = 1'b1; nz_val = regs_cur.y; end
			OP_ADC, OP_SBC: begin
				nxt.a        = sum9[7:0];
				nxt.p[FlagC] = sum9[8];
				nxt.p[FlagV] = add_ovf;
				nz_en        = 1'b1;
				nz_val       = sum9[7:0];
			end
			OP_INC: begin
				nz_val         = mem_data + 8'd1;
				nz_en          = 1'b1;
				acc.mem_write  = 1'b1;
				acc.write_data = nz_val;
			end
			OP_DEC: begin
				nz_val         = mem_data - 8'd1;
				nz_en          = 1'b1;
				acc.mem_write  = 1'b1;
				acc.write_data = nz_val;
			end
			OP_INX: begin nxt.x = regs_cur.x + 8'd1; nz_en = 1'b1; nz_val = nxt.x; end
			OP_DEX: begin nxt.x = regs_cur.x - 8'd1; nz_en = 1'b1; nz_val = nxt.x; end
			OP_INY: begin nxt.y = regs_cur.y + 8'd1; nz_en = 1'b1; nz_val = nxt.y; end
			OP_DEY: begin nxt.y = regs_cur.y - 8'd1; nz_en = 1'b1; nz_val = nxt.y; end
			OP_ASL, OP_ROL: begin
				nxt.p[FlagC]   = mem_data[7];
				nz_val         = {mem_data[6:0],
					(operation == OP_ROL) ? regs_cur.p[FlagC] : 1'b0};
				nz_en          = 1'b1;
				acc.mem_write  = 1'b1;
				acc.write_data = nz_val;
			end
			OP_LSR, OP_ROR: begin
				nxt.p[FlagC]   = mem_data[0];
				nz_val         = {(operation == OP_ROR) ? regs_cur.p[FlagC] : 1'b0,
					mem_data[7:1]};
				nz_en          = 1'b1;
				acc.mem_write  = 1'b1;
				acc.write_data = nz_val;
			end
			OP_AND: begin
				nxt.a = regs_cur.a & mem_data; nz_en = 1'b1; nz_val = nxt.a;
			end
			OP_ORA: begin
				nxt.a = regs_cur.a | mem_data; nz_en = 1'b1; nz_val = nxt.a;
			end
			OP_EOR: begin
				nxt.a = regs_cur.a ^ mem_data; nz_en = 1'b1; nz_val = nxt.a;
			end
			OP_BIT: begin
				nxt.p[FlagZ] = ((regs_cur.a & mem_data) == 8'd0);
				nxt.p[FlagV] = mem_data[6];
				nxt.p[FlagN] = mem_data[7];
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				if (operation == OP_CPX) begin
					cmp_reg = regs_cur.x;
				end else if (operation == OP_CPY) begin
					cmp_reg = regs_cur.y;
				end
				nz_en = 1'b1;
			end
			OP_PHA, OP_PHP: begin
				acc.mem_write     = 1'b1;
				acc.stack_access  = 1'b1;
				acc.write_data    = (operation == OP_PHP) ? (regs_cur.p | PushBits)
					: regs_cur.a;
				acc.stack_address = {1'b1, regs_cur.sp};
				nxt.sp            = regs_cur.sp - 8'd1;
			end
			OP_PLA: begin
				acc.stack_access  = 1'b1;
				acc.stack_address = {1'b1, sp_inc};
				nxt.sp            = sp_inc;
				nxt.a             = mem_data;
				nz_en             = 1'b1;
				nz_val            = mem_data;
			end
			OP_PLP: begin
				acc.stack_access  = 1'b1;
				acc.stack_address = {1'b1, sp_inc};
				nxt.sp            = sp_inc;
				nxt.p             = (mem_data & PullMask) | (regs_cur.p & PushBits);
			end
			OP_TXS: nxt.sp = regs_cur.x;
			OP_TSX: begin nxt.x = regs_cur.sp; nz_en = 1'b1; nz_val = regs_cur.sp; end
			OP_CLC: nxt.p[FlagC] = 1'b0;
			OP_SEC: nxt.p[FlagC] = 1'b1;
			OP_CLI: nxt.p[FlagI] = 1'b0;
			OP_SEI: nxt.p[FlagI] = 1'b1;
			OP_CLD: nxt.p[FlagD] = 1'b0;
			OP_SED: nxt.p[FlagD] = 1'b1;
			OP_CLV: nxt.p[FlagV] = 1'b0;
			default: ;
		endcase

		// Compares set carry when no borrow occurs.
		diff9 = {1'b0, cmp_reg} - {1'b0, mem_data};
		if ((operation == OP_CMP) || (operation == OP_CPX) || (operation == OP_CPY)) begin
			nxt.p[FlagC] = ~diff9[8];
			nz_val       = diff9[7:0];
		end

		if (nz_en) begin
			nxt.p[FlagZ] = (nz_val == 8'd0);
			nxt.p[FlagN] = nz_val[7];
		end

		// Without a stack access the address shows the next push slot.
		if (!acc.stack_access) begin
			acc.stack_address = {1'b1, nxt.sp};
		end

		regs_next = nxt;
		access    = acc;
	end

endmodule

`default_nettype wire

>>> hdl/c6502_ex_chk.sv
`default_nettype none

module c6502_ex_chk
	import c6502_ex_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OutWidth-1:0] m_tdata
);

	// A stalled output item stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// No write means the write byte reads as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
		else $error("write data not zero without a write");

	// Stack addresses always fall in page one.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[18])
		else $error("stack address outside page one");

	// Status bit 5 stays set and bit 4 stays clear in the register file.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[56] && !m_tdata[55])
		else $error("status bits 4 and 5 corrupted");

endmodule

bind cpu6502_register_alu_execute c6502_ex_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> verif/cpu6502_register_alu_execute_tb.sv
`default_nettype none

module cpu6502_register_alu_execute_tb;
	import c6502_ex_pkg::*;

	// Codes past NOP decode as NOP in the block.
	localparam logic [5:0] OpUnusedLow  = 6'd43;
	localparam logic [5:0] OpUnusedHigh = 6'd63;
	localparam int RandomOps  = 500;
	localparam int HoldCycles = 300;
	localparam int CycleLimit = 200000;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// [5:0] operation, [13:6] mem_data, [15:14] zero
	logic [InWidth-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [0] mem_write, [8:1] write_data, [9] stack_access, [18:10] stack_address,
	// [26:19] acc_out, [34:27] index_x_out, [42:35] index_y_out,
	// [50:43] stack_pointer_out, [58:51] status_out, [63:59] zero
	logic [OutWidth-1:0] m_tdata;

	cpu6502_register_alu_execute i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// One decoded operation waiting to be sent.
	typedef struct {
		logic [5:0] op;
		logic [7:0] data;
		int         gap;
		bit         drain;
	} op_item_t;

	// Access and register file expected for one operation.
	typedef struct {
		access_t acc;
		regs_t   regs;
	} exec_result_t;

	op_item_t     op_items[$];
	exec_result_t pending_results[$];
	regs_t        cpu = RegsReset;

	int  gap_left = -1;
	int  stall_left = 0;
	bit  stall_on = 1'b0;
	logic hold_out = 1'b0;
	int  accepted_cnt = 0;
	int  checked_cnt = 0;
	int  error_cnt = 0;
	int  cycle_cnt = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Reset is held from the start and released on a falling edge, away from the active edge.
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Flag helpers for the predicted status register.
	function automatic void set_nz(input logic [7:0] v);
		cpu.p[FlagZ] = (v == 8'h00);
		cpu.p[FlagN] = v[7];
	endfunction

	function automatic void add_carry(input logic [7:0] m);
		logic [8:0] sum;
		sum = {1'b0, cpu.a} + {1'b0, m} + {8'h00, cpu.p[FlagC]};
		cpu.p[FlagC] = sum[8];
		cpu.p[FlagV] = (cpu.a[7] ^ sum[7]) & (m[7] ^ sum[7]);
		cpu.a = sum[7:0];
		set_nz(cpu.a);
	endfunction

	function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
		logic [7:0] diff;
		diff = r - m;
		cpu.p[FlagC] = (r >= m);
		set_nz(diff);
	endfunction

	// Runs one operation on the predicted register file.
	function automatic exec_result_t cpu_execute(input logic [5:0] op, input logic [7:0] m);
		exec_result_t r;
		logic [7:0] v;
		logic cin;
		r.acc = '0;
		cin = cpu.p[FlagC];
		v = 8'h00;
		case (op)
			OP_LDA: begin cpu.a = m; set_nz(m); end
			OP_STA: begin r.acc.mem_write = 1'b1; r.acc.write_data = cpu.a; end
			OP_LDX: begin cpu.x = m; set_nz(m); end
			OP_STX: begin r.acc.mem_write = 1'b1; r.acc.write_data = cpu.x; end
			OP_LDY: begin cpu.y = m; set_nz(m); end
			OP_STY: begin r.acc.mem_write = 1'b1; r.acc.write_data = cpu.y; end
			OP_TAX: begin cpu.x = cpu.a; set_nz(cpu.x); end
			OP_TXA: begin cpu.a = cpu.x; set_nz(cpu.a); end
			OP_TAY: begin cpu.y = cpu.a; set_nz(cpu.y); end
			OP_TYA: begin cpu.a = cpu.y; set_nz(cpu.a); end
			OP_ADC: add_carry(m);
			OP_SBC: add_carry(~m);
			OP_INC, OP_DEC, OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				case (op)
					OP_INC: v = m + 8'd1;
					OP_DEC: v = m - 8'd1;
					OP_ASL: v = {m[6:0], 1'b0};
					OP_LSR: v = {1'b0, m[7:1]};
					OP_ROL: v = {m[6:0], cin};
					default: v = {cin, m[7:1]};
				endcase
				if (op == OP_ASL || op == OP_ROL)
					cpu.p[FlagC] = m[7];
				else if (op == OP_LSR || op == OP_ROR)
					cpu.p[FlagC] = m[0];
				set_nz(v);
				r.acc.mem_write = 1'b1;
				r.acc.write_data = v;
			end
			OP_INX: begin cpu.x = cpu.x + 8'd1; set_nz(cpu.x); end
			OP_DEX: begin cpu.x = cpu.x - 8'd1; set_nz(cpu.x); end
			OP_INY: begin cpu.y = cpu.y + 8'd1; set_nz(cpu.y); end
			OP_DEY: begin cpu.y = cpu.y - 8'd1; set_nz(cpu.y); end
			OP_AND: begin cpu.a = cpu.a & m; set_nz(cpu.a); end
			OP_ORA: begin cpu.a = cpu.a | m; set_nz(cpu.a); end
			OP_EOR: begin cpu.a = cpu.a ^ m; set_nz(cpu.a); end
			OP_BIT: begin
				cpu.p[FlagZ] = ((cpu.a & m) == 8'h00);
				cpu.p[FlagV] = m[6];
				cpu.p[FlagN] = m[7];
			end
			OP_CMP: compare_reg(cpu.a, m);
			OP_CPX: compare_reg(cpu.x, m);
			OP_CPY: compare_reg(cpu.y, m);
			OP_PHA, OP_PHP: begin
				r.acc.mem_write = 1'b1;
				r.acc.stack_access = 1'b1;
				r.acc.write_data = (op == OP_PHA) ? cpu.a : (cpu.p | PushBits);
				r.acc.stack_address = {1'b1, cpu.sp};
				cpu.sp = cpu.sp - 8'd1;
			end
			OP_PLA: begin
				r.acc.stack_access = 1'b1;
				cpu.sp = cpu.sp + 8'd1;
				r.acc.stack_address = {1'b1, cpu.sp};
				cpu.a = m;
				set_nz(m);
			end
			OP_PLP: begin
				r.acc.stack_access = 1'b1;
				cpu.sp = cpu.sp + 8'd1;
				r.acc.stack_address = {1'b1, cpu.sp};
				cpu.p = (m & PullMask) | (cpu.p & PushBits);
			end
			OP_TXS: cpu.sp = cpu.x;
			OP_TSX: begin cpu.x = cpu.sp; set_nz(cpu.x); end
			OP_CLC: cpu.p[FlagC] = 1'b0;
			OP_SEC: cpu.p[FlagC] = 1'b1;
			OP_CLI: cpu.p[FlagI] = 1'b0;
			OP_SEI: cpu.p[FlagI] = 1'b1;
			OP_CLD: cpu.p[FlagD] = 1'b0;
			OP_SED: cpu.p[FlagD] = 1'b1;
			OP_CLV: cpu.p[FlagV] = 1'b0;
			default: ;
		endcase
		// Without a stack access the address shows the next push slot.
		if (!r.acc.stack_access)
			r.acc.stack_address = {1'b1, cpu.sp};
		r.regs = cpu;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [8:0] got,
			input logic [8:0] want);
		if (error_cnt < 40)
			$display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
				checked_cnt, what, got, want);
		error_cnt++;
	endtask

	task automatic compare_field(input string what, input logic [8:0] got,
			input logic [8:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic add_item(input logic [5:0] op, input logic [7:0] data, input int gap,
			input bit drain);
		op_item_t it;
		it.op = op;
		it.data = data;
		it.gap = gap;
		it.drain = drain;
		op_items.push_back(it);
	endtask

	// Driver: offers queued items, predicting each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin : driver
		logic offer;
		op_item_t cur;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left = -1;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				pending_results.push_back(cpu_execute(s_tdata[5:0], s_tdata[13:6]));
				accepted_cnt++;
				offer = 1'b0;
			end
			if (!offer && op_items.size() > 0) begin
				if (gap_left < 0)
					gap_left = op_items[0].gap;
				if (gap_left > 0) begin
					gap_left--;
				end else if (!op_items[0].drain || pending_results.size() == 0) begin
					cur = op_items.pop_front();
					s_tdata <= {2'b00, cur.data, cur.op};
					offer = 1'b1;
					gap_left = -1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// Monitor: checks each accepted result and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin : monitor
		logic rdy;
		exec_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				checked_cnt++;
				if (pending_results.size() == 0) begin
					report_mismatch("arrived with no operation pending", '0, '0);
				end else begin
					want = pending_results.pop_front();
					compare_field("mem_write", 9'(m_tdata[0]), 9'(want.acc.mem_write));
					compare_field("write_data", 9'(m_tdata[8:1]),
						9'(want.acc.write_data));
					compare_field("stack_access", 9'(m_tdata[9]),
						9'(want.acc.stack_access));
					compare_field("stack_address", m_tdata[18:10], want.acc.stack_address);
					compare_field("acc_out", 9'(m_tdata[26:19]), 9'(want.regs.a));
					compare_field("index_x_out", 9'(m_tdata[34:27]), 9'(want.regs.x));
					compare_field("index_y_out", 9'(m_tdata[42:35]), 9'(want.regs.y));
					compare_field("stack_pointer_out", 9'(m_tdata[50:43]),
						9'(want.regs.sp));
					compare_field("status_out", 9'(m_tdata[58:51]), 9'(want.regs.p));
				end
				// Switch at random between stretches with and without stalls.
				if (checked_cnt % 32 == 0)
					stall_on = $urandom_range(0, 1);
				stall_left = stall_on ? $urandom_range(0, 16) : 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = !hold_out;
			end
			m_tready <= rdy;
		end
	end

	// Long output hold-off while the sender keeps offering items.
	initial begin : output_holdoff
		while (accepted_cnt < 200)
			@(negedge clk);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_out <= 1'b0;
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles", cycle_cnt);
		$display("Regression FAIL");
		$finish;
	end

	// Stimulus and end of run.
	initial begin : stimulus
		logic [5:0] op;
		logic [7:0] d;
		bit burst;
		burst = 1'b0;

		// Directed: flag extremes, overflow, borrow, rotates through carry, BIT,
		// push/pull of status, TXS without flags, stack wrap and unused codes.
		add_item(OP_LDA, 8'h00, 0, 0);
		add_item(OP_LDA, 8'h80, 0, 0);
		add_item(OP_ADC, 8'h80, 0, 0);
		add_item(OP_ADC, 8'hFF, 0, 0);
		add_item(OP_LDA, 8'h7F, 0, 0);
		add_item(OP_ADC, 8'h01, 0, 0);
		add_item(OP_SBC, 8'h01, 0, 0);
		add_item(OP_SEC, 8'h00, 0, 0);
		add_item(OP_ROL, 8'h80, 0, 0);
		add_item(OP_ROR, 8'h01, 0, 0);
		add_item(OP_CLC, 8'h00, 0, 0);
		add_item(OP_ROR, 8'h00, 0, 0);
		add_item(OP_BIT, 8'hC0, 0, 0);
		add_item(OP_SED, 8'h00, 0, 0);
		add_item(OP_ADC, 8'h09, 0, 0);
		add_item(OP_PHP, 8'h00, 0, 0);
		add_item(OP_PLP, 8'hFF, 0, 0);
		add_item(OP_PLP, 8'h00, 0, 0);
		add_item(OP_LDX, 8'h00, 0, 0);
		add_item(OP_TXS, 8'h00, 0, 0);
		add_item(OP_PHA, 8'h00, 0, 0);
		add_item(OP_PLA, 8'h55, 0, 0);
		add_item(OP_INC, 8'hFF, 0, 0);
		add_item(OP_DEC, 8'h00, 0, 0);
		add_item(OP_CMP, 8'hFF, 0, 0);
		add_item(OpUnusedLow, 8'hFF, 0, 0);
		add_item(OpUnusedHigh, 8'hFF, 0, 1);

		// Random operations with data biased toward the boundary values.
		for (int i = 0; i < RandomOps; i++) begin
			if ($urandom_range(0, 9) == 0)
				op = 6'($urandom_range(OpUnusedLow, OpUnusedHigh));
			else
				op = 6'($urandom_range(OP_LDA, OP_NOP));
			case ($urandom_range(0, 7))
				0: d = 8'h00;
				1: d = 8'hFF;
				2: d = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
				default: d = 8'($urandom);
			endcase
			if (i % 40 == 0)
				burst = $urandom_range(0, 1);
			// Keep the input busy around the output hold-off so the block fills up.
			if (i >= 150 && i < 260)
				add_item(op, d, 0, 0);
			else
				add_item(op, d, burst ? 0 : $urandom_range(0, 16), (i % 97) == 96);
		end

		while (op_items.size() > 0 || s_tvalid || pending_results.size() > 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d operations and checked %0d results, %0d mismatches.",
			accepted_cnt, checked_cnt, error_cnt);
		$display("Covered all codes, back-to-back bursts, random stalls, a long hold-off and drains.");
		if (error_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
